[src/gti_pkg.sv]
// ----------------------------------------------------------------------------
// gti_pkg
// shared types and codes for the g-code toolpath interpreter
// ----------------------------------------------------------------------------
`default_nettype none

package gti_pkg;

	// default widths handed to the top level parameters
	localparam int VALUE_WIDTH_DEF   = 48;
	localparam int FRACTION_BITS_DEF = 16;

	// word letters, 0 = A
	localparam logic [4:0] LETTER_F = 5'd5;
	localparam logic [4:0] LETTER_G = 5'd6;
	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Y = 5'd24;
	localparam logic [4:0] LETTER_Z = 5'd25;

	// pending word slots
	localparam int NUM_SLOTS = 5;
	localparam logic [2:0] SLOT_X = 3'd0;
	localparam logic [2:0] SLOT_Y = 3'd1;
	localparam logic [2:0] SLOT_Z = 3'd2;
	localparam logic [2:0] SLOT_I = 3'd3;
	localparam logic [2:0] SLOT_J = 3'd4;

	// non-motion g numbers
	localparam int G_ABSOLUTE    = 90;
	localparam int G_INCREMENTAL = 91;
	localparam int G_MOTION_MAX  = 3;

	typedef enum logic [1:0] {
		MOTION_RAPID  = 2'd0,
		MOTION_LINEAR = 2'd1,
		MOTION_CW     = 2'd2,
		MOTION_CCW    = 2'd3
	} motion_t;

	// modal state
	typedef struct packed {
		motion_t motion;
		logic    absolute;
	} gti_mode_t;

	// result flags, is_rapid in the lowest bit
	typedef struct packed {
		logic clockwise;
		logic is_arc;
		logic is_rapid;
	} gti_flags_t;

endpackage

`default_nettype wire

[src/gti_resolve.sv]
// ----------------------------------------------------------------------------
// gti_resolve
// per-word decode, modal update and end-of-line target resolution
// ----------------------------------------------------------------------------
`default_nettype none

module gti_resolve #(
	parameter int VALUE_WIDTH   = gti_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = gti_pkg::FRACTION_BITS_DEF
) (
	input  wire logic [4:0]                     letter,
	input  wire logic signed [VALUE_WIDTH-1:0]  word_value,
	input  wire logic                           line_end,
	input  wire gti_pkg::gti_mode_t             mode,
	input  wire logic [gti_pkg::NUM_SLOTS-1:0]  present,
	input  wire logic signed [VALUE_WIDTH-1:0]  words [gti_pkg::NUM_SLOTS],
	input  wire logic signed [VALUE_WIDTH-1:0]  pos_x,
	input  wire logic signed [VALUE_WIDTH-1:0]  pos_y,
	input  wire logic signed [VALUE_WIDTH-1:0]  pos_z,
	input  wire logic signed [VALUE_WIDTH-1:0]  feed,
	output gti_pkg::gti_mode_t                  mode_nxt,
	output logic signed [VALUE_WIDTH-1:0]       feed_nxt,
	output logic                                word_we,
	output logic [2:0]                          word_slot,
	output logic [gti_pkg::NUM_SLOTS-1:0]       present_nxt,
	output logic signed [VALUE_WIDTH-1:0]       pos_x_nxt,
	output logic signed [VALUE_WIDTH-1:0]       pos_y_nxt,
	output logic signed [VALUE_WIDTH-1:0]       pos_z_nxt,
	output logic                                emit,
	output gti_pkg::gti_flags_t                 flags,
	output logic signed [VALUE_WIDTH-1:0]       center_x,
	output logic signed [VALUE_WIDTH-1:0]       center_y
);

	localparam logic [VALUE_WIDTH-1:0] SAT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] SAT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
		input logic signed [VALUE_WIDTH-1:0] a,
		input logic signed [VALUE_WIDTH-1:0] b
	);
		logic signed [VALUE_WIDTH-1:0] s;
		s = a + b;
		if ((a[VALUE_WIDTH-1] == b[VALUE_WIDTH-1]) && (s[VALUE_WIDTH-1] != a[VALUE_WIDTH-1]))
			return a[VALUE_WIDTH-1] ? SAT_MIN : SAT_MAX;
		return s;
	endfunction

	logic                           g_neg;
	logic [VALUE_WIDTH-1:0]         g_mag;
	logic [VALUE_WIDTH-1:0]         g_int;
	logic signed [VALUE_WIDTH-1:0]  w_eff [gti_pkg::NUM_SLOTS];
	logic [gti_pkg::NUM_SLOTS-1:0]  present_eff;
	logic signed [VALUE_WIDTH-1:0]  tx;
	logic signed [VALUE_WIDTH-1:0]  ty;
	logic signed [VALUE_WIDTH-1:0]  tz;
	logic                           arc;
	logic                           moved;
	logic                           has_axis;

	// g number truncated toward zero
	assign g_neg = word_value[VALUE_WIDTH-1];
	assign g_mag = g_neg ? (~word_value + 1'b1) : word_value;
	assign g_int = g_mag >> FRACTION_BITS;

	always_comb begin
		mode_nxt = mode;
		feed_nxt = feed;
		word_we   = 1'b0;
		word_slot = gti_pkg::SLOT_X;
		unique case (letter)
			gti_pkg::LETTER_G: begin
				if (!(g_neg && g_int != '0)) begin
					if (g_int <= VALUE_WIDTH'(gti_pkg::G_MOTION_MAX))
						mode_nxt.motion = gti_pkg::motion_t'(g_int[1:0]);
					else if (g_int == VALUE_WIDTH'(gti_pkg::G_ABSOLUTE))
						mode_nxt.absolute = 1'b1;
					else if (g_int == VALUE_WIDTH'(gti_pkg::G_INCREMENTAL))
						mode_nxt.absolute = 1'b0;
				end
			end
			gti_pkg::LETTER_F: feed_nxt = word_value;
			gti_pkg::LETTER_X: begin word_we = 1'b1; word_slot = gti_pkg::SLOT_X; end
			gti_pkg::LETTER_Y: begin word_we = 1'b1; word_slot = gti_pkg::SLOT_Y; end
			gti_pkg::LETTER_Z: begin word_we = 1'b1; word_slot = gti_pkg::SLOT_Z; end
			gti_pkg::LETTER_I: begin word_we = 1'b1; word_slot = gti_pkg::SLOT_I; end
			gti_pkg::LETTER_J: begin word_we = 1'b1; word_slot = gti_pkg::SLOT_J; end
			default: ;
		endcase
	end

	// pending words with the current word merged in
	always_comb begin
		for (int k = 0; k < gti_pkg::NUM_SLOTS; k++) begin
			if (word_we && word_slot == 3'(k)) begin
				w_eff[k]       = word_value;
				present_eff[k] = 1'b1;
			end else begin
				w_eff[k]       = words[k];
				present_eff[k] = present[k];
			end
		end
	end

	always_comb begin
		if (!present_eff[gti_pkg::SLOT_X])
			tx = pos_x;
		else if (mode_nxt.absolute)
			tx = w_eff[gti_pkg::SLOT_X];
		else
			tx = sat_add(pos_x, w_eff[gti_pkg::SLOT_X]);

		if (!present_eff[gti_pkg::SLOT_Y])
			ty = pos_y;
		else if (mode_nxt.absolute)
			ty = w_eff[gti_pkg::SLOT_Y];
		else
			ty = sat_add(pos_y, w_eff[gti_pkg::SLOT_Y]);

		if (!present_eff[gti_pkg::SLOT_Z])
			tz = pos_z;
		else if (mode_nxt.absolute)
			tz = w_eff[gti_pkg::SLOT_Z];
		else
			tz = sat_add(pos_z, w_eff[gti_pkg::SLOT_Z]);
	end

	assign has_axis = present_eff[gti_pkg::SLOT_X] | present_eff[gti_pkg::SLOT_Y]
		| present_eff[gti_pkg::SLOT_Z];
	assign arc = ((mode_nxt.motion == gti_pkg::MOTION_CW) || (mode_nxt.motion == gti_pkg::MOTION_CCW))
		&& (present_eff[gti_pkg::SLOT_I] || present_eff[gti_pkg::SLOT_J]);
	assign moved = (tx != pos_x) || (ty != pos_y);

	always_comb begin
		center_x = '0;
		center_y = '0;
		if (arc) begin
			center_x = present_eff[gti_pkg::SLOT_I] ? sat_add(pos_x, w_eff[gti_pkg::SLOT_I]) : pos_x;
			center_y = present_eff[gti_pkg::SLOT_J] ? sat_add(pos_y, w_eff[gti_pkg::SLOT_J]) : pos_y;
		end
	end

	always_comb begin
		present_nxt = present_eff;
		pos_x_nxt   = pos_x;
		pos_y_nxt   = pos_y;
		pos_z_nxt   = pos_z;
		emit        = 1'b0;
		if (line_end) begin
			present_nxt = '0;
			if (has_axis) begin
				pos_x_nxt = tx;
				pos_y_nxt = ty;
				pos_z_nxt = tz;
				emit      = arc || moved;
			end
		end
	end

	assign flags.is_rapid  = (mode_nxt.motion == gti_pkg::MOTION_RAPID);
	assign flags.is_arc    = arc;
	assign flags.clockwise = arc && (mode_nxt.motion == gti_pkg::MOTION_CW);

endmodule

`default_nettype wire

[src/gcode_toolpath_interpreter.sv]
// ----------------------------------------------------------------------------
// gcode_toolpath_interpreter
// modal g-code interpreter turning lexed words into line and arc segments
// ----------------------------------------------------------------------------
// Words arrive one per item on the slave stream: the letter in s_tuser, the
// signed fixed-point value in s_tdata and the end-of-line mark in s_tlast.
// G0..G3 and G90/G91 and F take effect at once; X/Y/Z/I/J are held until the
// last word of the line, which resolves the target and may send one segment
// on the master stream. The block takes one word every cycle: a word is
// captured in an input register, and from there the decode, the saturating
// position adds and the motion compare finish in one pass and update the
// modal state and the result register, from which a segment is offered
// on the master stream. The only stall comes from the result register:
// while it holds an untaken segment, a line end that would make another
// one waits in the input register and holds back the words behind it;
// words that make no segment retire. Reset brings G0, absolute mode, zero
// feed and the origin.
`default_nettype none

module gcode_toolpath_interpreter #(
	parameter int VALUE_WIDTH   = gti_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = gti_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// word stream in
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,  // word_value
	input  wire logic [4:0]                             s_tuser,  // letter
	input  wire logic                                   s_tlast,  // line_end
	// segment stream out
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// start_x, start_y, end_x, end_y, center_x, center_y, feed_rate
	output logic [((7*VALUE_WIDTH+7)/8)*8-1:0]          m_tdata,
	output logic [2:0]                                  m_tuser   // is_rapid, is_arc, clockwise
);

	localparam int OUT_W = ((7*VALUE_WIDTH+7)/8)*8;

	// input register
	logic                           valid_s1;
	logic [4:0]                     letter_s1;
	logic signed [VALUE_WIDTH-1:0]  value_s1;
	logic                           line_end_s1;

	// modal state and pending words
	gti_pkg::gti_mode_t             mode_q;
	logic signed [VALUE_WIDTH-1:0]  feed_q;
	logic signed [VALUE_WIDTH-1:0]  pos_x_q;
	logic signed [VALUE_WIDTH-1:0]  pos_y_q;
	logic signed [VALUE_WIDTH-1:0]  pos_z_q;
	logic signed [VALUE_WIDTH-1:0]  words_q [gti_pkg::NUM_SLOTS];
	logic [gti_pkg::NUM_SLOTS-1:0]  present_q;

	// result register
	logic                           m_valid_q;
	logic signed [VALUE_WIDTH-1:0]  start_x_q;
	logic signed [VALUE_WIDTH-1:0]  start_y_q;
	logic signed [VALUE_WIDTH-1:0]  end_x_q;
	logic signed [VALUE_WIDTH-1:0]  end_y_q;
	logic signed [VALUE_WIDTH-1:0]  center_x_q;
	logic signed [VALUE_WIDTH-1:0]  center_y_q;
	logic signed [VALUE_WIDTH-1:0]  feed_rate_q;
	gti_pkg::gti_flags_t            flags_q;

	// resolver outputs
	gti_pkg::gti_mode_t             mode_nxt;
	logic signed [VALUE_WIDTH-1:0]  feed_nxt;
	logic                           word_we;
	logic [2:0]                     word_slot;
	logic [gti_pkg::NUM_SLOTS-1:0]  present_nxt;
	logic signed [VALUE_WIDTH-1:0]  pos_x_nxt;
	logic signed [VALUE_WIDTH-1:0]  pos_y_nxt;
	logic signed [VALUE_WIDTH-1:0]  pos_z_nxt;
	logic                           emit;
	gti_pkg::gti_flags_t            flags;
	logic signed [VALUE_WIDTH-1:0]  center_x;
	logic signed [VALUE_WIDTH-1:0]  center_y;

	logic out_free;
	logic advance;
	logic s_fire;

	gti_resolve #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_resolve (
		.letter      (letter_s1),
		.word_value  (value_s1),
		.line_end    (line_end_s1),
		.mode        (mode_q),
		.present     (present_q),
		.words       (words_q),
		.pos_x       (pos_x_q),
		.pos_y       (pos_y_q),
		.pos_z       (pos_z_q),
		.feed        (feed_q),
		.mode_nxt    (mode_nxt),
		.feed_nxt    (feed_nxt),
		.word_we     (word_we),
		.word_slot   (word_slot),
		.present_nxt (present_nxt),
		.pos_x_nxt   (pos_x_nxt),
		.pos_y_nxt   (pos_y_nxt),
		.pos_z_nxt   (pos_z_nxt),
		.emit        (emit),
		.flags       (flags),
		.center_x    (center_x),
		.center_y    (center_y)
	);

	// the word in the input register retires unless it has a segment and
	// the result register is still full
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			letter_s1   <= s_tuser;
			value_s1    <= s_tdata[VALUE_WIDTH-1:0];
			line_end_s1 <= s_tlast;
		end
	end

	// modal state, updated as each word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '{motion: gti_pkg::MOTION_RAPID, absolute: 1'b1};
			feed_q    <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			pos_z_q   <= '0;
			present_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_nxt;
			feed_q    <= feed_nxt;
			pos_x_q   <= pos_x_nxt;
			pos_y_q   <= pos_y_nxt;
			pos_z_q   <= pos_z_nxt;
			present_q <= present_nxt;
		end
	end

	// pending word values, only read behind their present bits
	always_ff @(posedge clk) begin
		if (advance && word_we) begin
			words_q[word_slot] <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// segment start is the position before the move
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			start_x_q   <= pos_x_q;
			start_y_q   <= pos_y_q;
			end_x_q     <= pos_x_nxt;
			end_y_q     <= pos_y_nxt;
			center_x_q  <= center_x;
			center_y_q  <= center_y;
			feed_rate_q <= feed_nxt;
			flags_q     <= flags;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({feed_rate_q, center_y_q, center_x_q, end_y_q, end_x_q,
		start_y_q, start_x_q});
	assign m_tuser  = flags_q;

	// pending words never survive a line end
	a_present_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end_s1 |=> present_q == '0)
		else $error("pending words kept across line end");

	// segments come only from the last word of a line
	a_emit_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |-> line_end_s1)
		else $error("segment from a word that is not a line end");

	// a held segment blocks the next one from retiring
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && m_valid_q && !m_tready |=> valid_s1)
		else $error("segment retired while result register full");

	// arcs are never rapid, and only arcs turn clockwise
	a_flag_combo: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(flags_q.is_arc && flags_q.is_rapid)
			&& !(flags_q.clockwise && !flags_q.is_arc))
		else $error("inconsistent segment flags");

	// positions only move when a line ends
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !line_end_s1 |=> $stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q))
		else $error("position changed mid line");

endmodule

`default_nettype wire

[tb/gcode_toolpath_interpreter_test.sv]
// ----------------------------------------------------------------------------
// gcode_toolpath_interpreter_test
// self-checking stream test of the g-code toolpath interpreter
// ----------------------------------------------------------------------------
// Lexed words are fed to the word stream from a queue filled up front. The
// queue holds a short hand-written program and then random lines: mostly
// well-formed lines with random letters, values and order, plus noise words.
// A software copy of the modal state predicts the segment that each line end
// gives. Each segment that leaves the block is checked field by field against
// the oldest prediction. Both sides pause at random. Once the receiver holds
// off long enough for the block to back up and stall its word input.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_toolpath_interpreter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = gti_pkg::VALUE_WIDTH_DEF;
	localparam int FB = gti_pkg::FRACTION_BITS_DEF;
	localparam int TW = ((VW + 7) / 8) * 8;
	localparam int DW = ((7 * VW + 7) / 8) * 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_WORDS = 450;

	localparam logic [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
	// minus one half in fixed point, truncates to g0
	localparam logic [VW-1:0] HALF_NEG = {VW{1'b1}} << (FB - 1);
	localparam logic [VW-1:0] HALF_POS = VW'(1) << (FB - 1);
	// letter code above z, must be ignored
	localparam logic [4:0] LETTER_TOP = 5'd31;

	// positions of the coordinates in m_tdata, start_x lowest
	localparam int CO_START_X  = 0;
	localparam int CO_START_Y  = 1;
	localparam int CO_END_X    = 2;
	localparam int CO_END_Y    = 3;
	localparam int CO_CENTER_X = 4;
	localparam int CO_CENTER_Y = 5;
	localparam int CO_FEED     = 6;
	localparam int NUM_COORDS  = 7;

	typedef struct {
		logic [4:0]    letter;
		logic [VW-1:0] value;
		logic          eol;
		int            gap;
	} gword_t;

	typedef struct {
		logic [NUM_COORDS-1:0][VW-1:0] coords;
		gti_pkg::gti_flags_t           flags;
	} segment_t;

	string coord_label [NUM_COORDS] = '{"start_x", "start_y", "end_x", "end_y",
		"center_x", "center_y", "feed_rate"};

	// clock, reset and the two streams, all known from time zero
	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic [TW-1:0] s_tdata  = '0;  // word_value
	logic [4:0]    s_tuser  = '0;  // letter
	logic          s_tlast  = 1'b0;  // line_end
	logic          m_tready = 1'b0;
	wire logic          s_tready;
	wire logic          m_tvalid;
	// start_x, start_y, end_x, end_y, center_x, center_y, feed_rate
	wire logic [DW-1:0] m_tdata;
	wire logic [2:0]    m_tuser;  // is_rapid, is_arc, clockwise

	gcode_toolpath_interpreter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// words waiting to be sent and segments waiting to come out
	gword_t   word_queue [$];
	segment_t expected_segments [$];

	// modal state of the interpreter as predicted, at its reset values
	gti_pkg::motion_t   mode_q     = gti_pkg::MOTION_RAPID;
	logic               absolute_q = 1'b1;
	logic [VW-1:0]      feed_q     = '0;
	logic [VW-1:0]      pos_q [3]  = '{default: '0};
	logic [VW-1:0]      pending_q [gti_pkg::NUM_SLOTS];
	logic [gti_pkg::NUM_SLOTS-1:0] present_q = '0;

	// handshake history as seen at the last rising edge
	logic in_taken       = 1'b0;
	logic out_taken      = 1'b0;
	logic result_waiting = 1'b0;

	bit dense_gaps = 1'b0;
	bit hold_off   = 1'b0;
	int idle_cnt    = 0;
	int stall_left  = 0;
	int calm_left   = 0;
	int quiet_cycles = 0;

	int errors        = 0;
	int words_in      = 0;
	int segments_seen = 0;
	int arcs_seen     = 0;
	int rapids_seen   = 0;
	int still_lines   = 0;
	int bare_lines    = 0;

	initial begin : clock_gen
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- helpers

	function automatic logic [VW-1:0] fx(input int n);
		logic [31:0]   nb;
		logic [VW-1:0] r;
		nb = n;
		r = {{(VW-32){nb[31]}}, nb};
		return r << FB;
	endfunction

	function automatic logic [VW-1:0] add_clamp(input logic [VW-1:0] a,
			input logic [VW-1:0] b);
		logic [VW-1:0] s;
		s = a + b;
		if (a[VW-1] == b[VW-1] && s[VW-1] != a[VW-1])
			return a[VW-1] ? VALUE_MIN : VALUE_MAX;
		return s;
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		if (errors < 40)
			$display("mismatch at segment %0d: %s got %h want %h",
				segments_seen, what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------- predictor

	// one word through the modal interpreter; a line end may queue a segment
	task automatic interpret_word(input logic [4:0] letter, input logic [VW-1:0] value,
			input logic eol);
		int            slot;
		int            a;
		logic [VW-1:0] mag;
		logic [VW-1:0] whole;
		logic [VW-1:0] tgt [3];
		logic [VW-1:0] cx;
		logic [VW-1:0] cy;
		logic          arc;
		logic          moved;
		segment_t      seg;
		slot = -1;
		case (letter)
		gti_pkg::LETTER_G: begin
			// g number truncated toward zero, negatives of -1 and below ignored
			mag = value[VW-1] ? -value : value;
			whole = mag >> FB;
			if (!(value[VW-1] && whole != 0)) begin
				if (whole <= VW'(gti_pkg::G_MOTION_MAX))
					mode_q = gti_pkg::motion_t'(whole[1:0]);
				else if (whole == VW'(gti_pkg::G_ABSOLUTE))
					absolute_q = 1'b1;
				else if (whole == VW'(gti_pkg::G_INCREMENTAL))
					absolute_q = 1'b0;
			end
		end
		gti_pkg::LETTER_F: feed_q = value;
		gti_pkg::LETTER_X: slot = gti_pkg::SLOT_X;
		gti_pkg::LETTER_Y: slot = gti_pkg::SLOT_Y;
		gti_pkg::LETTER_Z: slot = gti_pkg::SLOT_Z;
		gti_pkg::LETTER_I: slot = gti_pkg::SLOT_I;
		gti_pkg::LETTER_J: slot = gti_pkg::SLOT_J;
		default: ;
		endcase
		if (slot >= 0) begin
			pending_q[slot] = value;
			present_q[slot] = 1'b1;
		end
		if (!eol)
			return;
		// a line with no axis word only drops its pending words
		if (present_q[gti_pkg::SLOT_Z:gti_pkg::SLOT_X] == '0) begin
			present_q = '0;
			bare_lines++;
			return;
		end
		for (a = 0; a < 3; a++)
			tgt[a] = !present_q[a] ? pos_q[a]
				: absolute_q ? pending_q[a] : add_clamp(pos_q[a], pending_q[a]);
		arc = (mode_q == gti_pkg::MOTION_CW || mode_q == gti_pkg::MOTION_CCW)
			&& (present_q[gti_pkg::SLOT_I] || present_q[gti_pkg::SLOT_J]);
		cx = '0;
		cy = '0;
		if (arc) begin
			cx = present_q[gti_pkg::SLOT_I]
				? add_clamp(pos_q[gti_pkg::SLOT_X], pending_q[gti_pkg::SLOT_I])
				: pos_q[gti_pkg::SLOT_X];
			cy = present_q[gti_pkg::SLOT_J]
				? add_clamp(pos_q[gti_pkg::SLOT_Y], pending_q[gti_pkg::SLOT_J])
				: pos_q[gti_pkg::SLOT_Y];
		end
		moved = tgt[gti_pkg::SLOT_X] != pos_q[gti_pkg::SLOT_X]
			|| tgt[gti_pkg::SLOT_Y] != pos_q[gti_pkg::SLOT_Y];
		present_q = '0;
		if (arc || moved) begin
			seg.coords[CO_START_X]  = pos_q[gti_pkg::SLOT_X];
			seg.coords[CO_START_Y]  = pos_q[gti_pkg::SLOT_Y];
			seg.coords[CO_END_X]    = tgt[gti_pkg::SLOT_X];
			seg.coords[CO_END_Y]    = tgt[gti_pkg::SLOT_Y];
			seg.coords[CO_CENTER_X] = cx;
			seg.coords[CO_CENTER_Y] = cy;
			seg.coords[CO_FEED]     = feed_q;
			seg.flags.is_rapid  = mode_q == gti_pkg::MOTION_RAPID;
			seg.flags.is_arc    = arc;
			seg.flags.clockwise = arc && mode_q == gti_pkg::MOTION_CW;
			expected_segments = {expected_segments, seg};
		end else begin
			// no plane motion: position and z still follow the target
			still_lines++;
		end
		for (a = 0; a < 3; a++)
			pos_q[a] = tgt[a];
	endtask

	task automatic check_segment(input logic [DW-1:0] data, input logic [2:0] user);
		logic [NUM_COORDS-1:0][VW-1:0] got;
		gti_pkg::gti_flags_t           got_flags;
		segment_t                      want;
		int                            k;
		got = data[NUM_COORDS*VW-1:0];
		got_flags = gti_pkg::gti_flags_t'(user);
		if (expected_segments.size() == 0) begin
			report_mismatch("unexpected segment", got[CO_END_X], '0);
			return;
		end
		want = expected_segments.pop_front();
		for (k = 0; k < NUM_COORDS; k++)
			if (got[k] !== want.coords[k])
				report_mismatch(coord_label[k], got[k], want.coords[k]);
		if (got_flags.is_rapid !== want.flags.is_rapid)
			report_mismatch("is_rapid", VW'(got_flags.is_rapid), VW'(want.flags.is_rapid));
		if (got_flags.is_arc !== want.flags.is_arc)
			report_mismatch("is_arc", VW'(got_flags.is_arc), VW'(want.flags.is_arc));
		if (got_flags.clockwise !== want.flags.clockwise)
			report_mismatch("clockwise", VW'(got_flags.clockwise), VW'(want.flags.clockwise));
		segments_seen++;
		if (want.flags.is_arc)
			arcs_seen++;
		if (want.flags.is_rapid)
			rapids_seen++;
	endtask

	// ------------------------------------------------------------- stimulus

	task automatic queue_word(input logic [4:0] letter, input logic [VW-1:0] value,
			input logic eol);
		gword_t w;
		w.letter = letter;
		w.value  = value;
		w.eol    = eol;
		w.gap    = dense_gaps ? 0 : $urandom_range(0, 19);
		word_queue = {word_queue, w};
	endtask

	// mostly small coordinates, sometimes any bit pattern, a range extreme, zero or all ones
	function automatic logic [VW-1:0] pick_coord();
		logic [VW-1:0] v;
		case ($urandom_range(0, 9))
		0: v = VW'({$urandom, $urandom});
		1: case ($urandom_range(0, 3))
			0: v = VALUE_MAX;
			1: v = VALUE_MIN;
			2: v = '0;
			default: v = '1;
			endcase
		default: v = fx(int'($urandom_range(0, 4000)) - 2000)
			| VW'($urandom_range(0, (1 << FB) - 1));
		endcase
		return v;
	endfunction

	function automatic logic [VW-1:0] pick_g();
		logic [VW-1:0] frac;
		frac = VW'($urandom_range(0, (1 << FB) - 1));
		case ($urandom_range(0, 11))
		0: return fx(gti_pkg::G_ABSOLUTE) | frac;
		1: return fx(gti_pkg::G_INCREMENTAL) | frac;
		2: return -(frac | VW'(1));  // small negative, counts as g0
		3: return fx(int'($urandom_range(4, 120))) | frac;  // mostly not a known g number
		4: return VW'({$urandom, $urandom});
		default: return fx(int'($urandom_range(0, gti_pkg::G_MOTION_MAX))) | frac;
		endcase
	endfunction

	// one random line: modal words, axis and offset words, now and then an
	// ignored letter or a repeated word, in random order
	task automatic queue_line();
		gword_t     buf_q [$];
		gword_t     w;
		gword_t     tmp;
		logic [4:0] axis_letter [5];
		int         i;
		int         j;
		int         n;
		axis_letter = '{gti_pkg::LETTER_X, gti_pkg::LETTER_Y, gti_pkg::LETTER_Z,
			gti_pkg::LETTER_I, gti_pkg::LETTER_J};
		if ($urandom_range(0, 9) == 0) begin
			// noise: any letter, any value, line ends anywhere
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				queue_word(5'($urandom_range(0, 31)), VW'({$urandom, $urandom}),
					1'($urandom_range(0, 1)));
			return;
		end
		w.eol = 1'b0;
		w.gap = 0;
		if ($urandom_range(0, 2) == 0) begin
			w.letter = gti_pkg::LETTER_G;
			w.value  = pick_g();
			buf_q = {buf_q, w};
		end
		if ($urandom_range(0, 3) == 0) begin
			w.letter = gti_pkg::LETTER_F;
			w.value  = pick_coord();
			buf_q = {buf_q, w};
		end
		for (i = 0; i < 5; i++)
			if ($urandom_range(0, 1) == 1) begin
				w.letter = axis_letter[i];
				w.value  = pick_coord();
				buf_q = {buf_q, w};
			end
		if (buf_q.size() == 0 || $urandom_range(0, 4) == 0) begin
			w.letter = axis_letter[$urandom_range(0, 2)];
			w.value  = pick_coord();
			buf_q = {buf_q, w};
		end
		if ($urandom_range(0, 7) == 0) begin
			w.letter = axis_letter[$urandom_range(0, 4)];
			w.value  = pick_coord();
			buf_q = {buf_q, w};
		end
		if ($urandom_range(0, 5) == 0) begin
			do
				w.letter = 5'($urandom_range(0, 31));
			while (w.letter inside {gti_pkg::LETTER_F, gti_pkg::LETTER_G,
				gti_pkg::LETTER_I, gti_pkg::LETTER_J, gti_pkg::LETTER_X,
				gti_pkg::LETTER_Y, gti_pkg::LETTER_Z});
			w.value = VW'({$urandom, $urandom});
			buf_q = {buf_q, w};
		end
		for (i = buf_q.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = buf_q[i];
			buf_q[i] = buf_q[j];
			buf_q[j] = tmp;
		end
		for (i = 0; i < buf_q.size(); i++)
			queue_word(buf_q[i].letter, buf_q[i].value, i == buf_q.size() - 1);
	endtask

	// ---------------------------------------------------------------- sender

	// presents the next word once its gap has run out, holds it until taken
	always @(negedge clk) begin : sender
		gword_t w;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (word_queue.size() != 0 && idle_cnt >= word_queue[0].gap) begin
				w = word_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= TW'(w.value);
				s_tuser  <= w.letter;
				s_tlast  <= w.eol;
				idle_cnt <= 0;
			end else begin
				s_tvalid <= 1'b0;
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	// -------------------------------------------------------------- receiver

	// per segment a random stall, counted only while it waits; now and then
	// a calm stretch with no stalls; long hold-off from its own process
	always @(negedge clk) begin : receiver
		int draw;
		if (arst_n) begin
			if (out_taken) begin
				draw = calm_left > 0 ? 0 : $urandom_range(0, 19);
				if (calm_left > 0)
					calm_left <= calm_left - 1;
				else if ($urandom_range(0, 9) == 0)
					calm_left <= 24;
				stall_left <= draw;
				m_tready <= draw == 0 && !hold_off;
			end else if (hold_off) begin
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				if (result_waiting)
					stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : pressure
		while (words_in < 140)
			@(negedge clk);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// --------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken       <= s_tvalid && s_tready;
			out_taken      <= m_tvalid && m_tready;
			result_waiting <= m_tvalid && !m_tready;
			if (m_tvalid && m_tready)
				check_segment(m_tdata, m_tuser);
			if (s_tvalid && s_tready) begin
				interpret_word(s_tuser, s_tdata[VW-1:0], s_tlast);
				words_in++;
			end
		end
	end

	// ends the run when neither stream has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d segments outstanding",
					IDLE_LIMIT, expected_segments.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------ main

	initial begin : main
		int generated;

		// directed program
		// rapid to the range extremes from the origin
		queue_word(gti_pkg::LETTER_X, VALUE_MAX, 1'b0);
		queue_word(gti_pkg::LETTER_Y, VALUE_MIN, 1'b1);
		// g1.99 truncates to g1, largest feed, cut back to the origin
		queue_word(gti_pkg::LETTER_G, fx(1) | fx(1) - 1, 1'b0);
		queue_word(gti_pkg::LETTER_F, VALUE_MAX, 1'b0);
		queue_word(gti_pkg::LETTER_X, '0, 1'b0);
		queue_word(gti_pkg::LETTER_Y, '0, 1'b1);
		// g-0.5 counts as g0
		queue_word(gti_pkg::LETTER_G, HALF_NEG, 1'b0);
		queue_word(gti_pkg::LETTER_X, fx(5), 1'b1);
		// clockwise arc with only i
		queue_word(gti_pkg::LETTER_G, fx(2) | HALF_POS, 1'b0);
		queue_word(gti_pkg::LETTER_I, fx(3), 1'b0);
		queue_word(gti_pkg::LETTER_X, fx(10), 1'b0);
		queue_word(gti_pkg::LETTER_Y, fx(1), 1'b1);
		// full circle with only j: no plane motion, still an arc
		queue_word(gti_pkg::LETTER_G, fx(3), 1'b0);
		queue_word(gti_pkg::LETTER_J, VALUE_MIN, 1'b0);
		queue_word(gti_pkg::LETTER_X, fx(10), 1'b1);
		// arc mode without offsets gives a chord
		queue_word(gti_pkg::LETTER_Y, fx(4), 1'b1);
		// z only: no segment, position moves
		queue_word(gti_pkg::LETTER_Z, VALUE_MIN, 1'b1);
		// line without an axis word, ending on a letter past z
		queue_word(gti_pkg::LETTER_F, fx(100), 1'b0);
		queue_word(LETTER_TOP, VALUE_MAX, 1'b1);
		// incremental, saturating end and center
		queue_word(gti_pkg::LETTER_G, fx(gti_pkg::G_INCREMENTAL), 1'b0);
		queue_word(gti_pkg::LETTER_I, VALUE_MAX, 1'b0);
		queue_word(gti_pkg::LETTER_X, VALUE_MAX, 1'b1);
		// repeated word, the later one counts
		queue_word(gti_pkg::LETTER_X, fx(1), 1'b0);
		queue_word(gti_pkg::LETTER_X, fx(-7), 1'b1);

		// random lines, with two back-to-back stretches
		generated = 0;
		while (generated < RANDOM_WORDS) begin
			dense_gaps = (generated >= 110 && generated < 230)
				|| (generated >= 350 && generated < 400);
			n_before: begin
				int before_size;
				before_size = word_queue.size();
				queue_line();
				generated += word_queue.size() - before_size;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_segments.size() != 0)
			@(posedge clk);
		// any segment that still comes out here is unexpected
		repeat (12) @(posedge clk);

		$display("words in: %0d, segments checked: %0d (%0d arcs, %0d rapid)",
			words_in, segments_seen, arcs_seen, rapids_seen);
		$display("line ends without a segment: %0d no plane motion, %0d no axis word",
			still_lines, bare_lines);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
